// ----- rtl/f12cw_pkg.sv -----
// ----------------------------------------------------------------------------
// f12cw_pkg
// Shared types and constants for the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
`default_nettype none

package f12cw_pkg;

    localparam logic [11:0] END_MARK           = 12'hFF0;
    localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_START = 2'd1,
        STS_TRUNCATED = 2'd2,
        STS_BAD_LINK  = 2'd3
    } walk_status_t;

    typedef enum logic {
        REQ_WRITE_BYTE = 1'b0,
        REQ_WALK       = 1'b1
    } req_type_t;

    // controller -> datapath
    typedef struct packed {
        logic wr_byte;     // store one table byte
        logic start_walk;  // load start cluster, clear link count
        logic fetch;       // table read in flight, form sector product
        logic emit;        // load output register, step to next link
    } f12cw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register empty or being taken
        logic final_item;  // the result under evaluation ends the walk
    } f12cw_sts_t;

endpackage

`default_nettype wire

// ----- rtl/fat12_cluster_chain_walker.sv -----
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Holds a packed FAT12 table and follows cluster chains through it.
//
// Input stream (s_): s_tuser = 0 stores s_tdata byte fat_byte at fat_byte_index
// and returns nothing; s_tuser = 1 walks the chain from start_cluster.
// Output stream (m_): one transaction per cluster of the chain, carrying the
// cluster and its first data sector; m_tlast marks the final one and m_tuser
// its status (ok, bad start, truncated, bad link).
// A walk steps each cluster through a table read, then unpack and check,
// set by the registered read stage of the table memory. A new request is
// taken only once the walk in hand has issued its last result.
// A stalled receiver holds the output register and the walk waits in its
// evaluate step; nothing is lost. Reset clears the sequencer, the output
// valid and the APB registers (data_area_start 0, sectors_per_cluster 1);
// the table memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_walker
    import f12cw_pkg::*;
#(
    parameter int FAT_BYTES = 8192,
    parameter int MAX_CHAIN = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // fat_byte_index[12:0], fat_byte[20:13],
                                       // start_cluster[32:21], zero[39:33]
    input  wire logic        s_tuser,  // req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // cluster[11:0], sector[31:12]
    output logic             m_tlast,
    output logic [1:0]       m_tuser   // status
);

    localparam logic REG_DATA_START = 1'b0;
    localparam logic REG_SPC        = 1'b1;

    logic [15:0]  data_start_reg;
    logic [7:0]   spc_reg;
    logic         cfg_wr;

    f12cw_cmd_t   cmd;
    f12cw_sts_t   sts;
    logic [11:0]  cluster;
    logic [19:0]  sector;
    walk_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_start_reg <= 16'd0;
            spc_reg        <= 8'd1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_DATA_START: data_start_reg <= pwdata[15:0];
                REG_SPC:        spc_reg        <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DATA_START: prdata = {16'd0, data_start_reg};
            REG_SPC:        prdata = {24'd0, spc_reg};
            default:        prdata = 32'd0;
        endcase
    end

    f12cw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    f12cw_dpath #(
        .FAT_BYTES (FAT_BYTES),
        .MAX_CHAIN (MAX_CHAIN)
    ) u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .fat_byte_index      (s_tdata[12:0]),
        .fat_byte            (s_tdata[20:13]),
        .start_cluster       (s_tdata[32:21]),
        .data_area_start     (data_start_reg),
        .sectors_per_cluster (spc_reg),
        .m_tready            (m_tready),
        .m_tvalid            (m_tvalid),
        .cluster             (cluster),
        .sector              (sector),
        .last                (m_tlast),
        .status              (status)
    );

    assign m_tdata = {sector, cluster};
    assign m_tuser = status;

endmodule

`default_nettype wire

// ----- rtl/f12cw_ctrl.sv -----
// ----------------------------------------------------------------------------
// f12cw_ctrl
// Sequencer: accepts requests, steps each chain link through fetch and
// evaluate, waits on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module f12cw_ctrl
    import f12cw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       req_type,
    output logic            s_tready,
    output f12cw_cmd_t      cmd,
    input  wire f12cw_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_type == REQ_WALK) begin
                        cmd.start_walk = 1'b1;
                        state_next     = ST_FETCH;
                    end else begin
                        cmd.wr_byte = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.final_item ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/f12cw_dpath.sv -----
// ----------------------------------------------------------------------------
// f12cw_dpath
// Table memory, entry unpack, link checks, sector arithmetic and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module f12cw_dpath
    import f12cw_pkg::*;
#(
    parameter int FAT_BYTES = 8192,
    parameter int MAX_CHAIN = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire f12cw_cmd_t  cmd,
    output f12cw_sts_t       sts,
    input  wire logic [12:0] fat_byte_index,
    input  wire logic [7:0]  fat_byte,
    input  wire logic [11:0] start_cluster,
    input  wire logic [15:0] data_area_start,
    input  wire logic [7:0]  sectors_per_cluster,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [11:0]      cluster,
    output logic [19:0]      sector,
    output logic             last,
    output walk_status_t     status
);

    localparam int AW          = $clog2(FAT_BYTES);
    localparam int CW          = $clog2(MAX_CHAIN + 1);
    localparam int NUM_TRIPLES = FAT_BYTES / 3;

    logic [7:0]  mem [FAT_BYTES];

    logic [11:0]  cur_reg;
    logic [CW-1:0] cnt_reg;
    logic          bad_start_reg;
    logic [19:0]   prod_reg;
    logic [7:0]    rd_a_reg, rd_b_reg;

    logic          m_valid_reg;
    logic [11:0]   cluster_reg;
    logic [19:0]   sector_reg;
    logic          last_reg;
    walk_status_t  status_reg;

    logic [AW+12:0] wr_wide, rd_a_wide, rd_b_wide;
    logic [AW-1:0]  wr_addr, rd_a_addr, rd_b_addr;
    logic           wr_in_range;
    logic [10:0]    triple;
    logic [12:0]    off_a, off_b;
    logic           entry_in_range;
    logic [11:0]    entry;
    logic           is_end, is_bad_link, is_trunc, final_item;
    logic [19:0]    sector_calc;
    walk_status_t   status_calc;
    logic           out_free;

    // byte write decode
    assign wr_in_range = {4'b0, fat_byte_index} < 17'(FAT_BYTES);
    assign wr_wide     = {{AW{1'b0}}, fat_byte_index};
    assign wr_addr     = wr_wide[AW-1:0];

    // two entries per byte triple; odd entries start in the middle byte
    assign triple    = cur_reg[11:1];
    assign off_a     = 13'({triple, 1'b0}) + 13'(triple) + 13'(cur_reg[0]);
    assign off_b     = off_a + 13'd1;
    assign rd_a_wide = {{AW{1'b0}}, off_a};
    assign rd_b_wide = {{AW{1'b0}}, off_b};
    assign rd_a_addr = rd_a_wide[AW-1:0];
    assign rd_b_addr = rd_b_wide[AW-1:0];

    assign entry_in_range = {6'b0, triple} < 17'(NUM_TRIPLES);

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte && wr_in_range) begin
            mem[wr_addr] <= fat_byte;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb begin
        if (!entry_in_range) begin
            entry = 12'd0;
        end else if (cur_reg[0]) begin
            entry = {rd_b_reg, rd_a_reg[7:4]};
        end else begin
            entry = {rd_b_reg[3:0], rd_a_reg};
        end
    end

    assign is_end      = entry >= END_MARK;
    assign is_bad_link = entry < FIRST_DATA_CLUSTER;
    assign is_trunc    = cnt_reg >= CW'(MAX_CHAIN - 1);
    assign final_item  = bad_start_reg || is_end || is_bad_link || is_trunc;
    assign sector_calc = bad_start_reg ? 20'd0 : ({4'b0, data_area_start} + prod_reg);

    always_comb begin
        if (bad_start_reg) begin
            status_calc = STS_BAD_START;
        end else if (is_end) begin
            status_calc = STS_OK;
        end else if (is_bad_link) begin
            status_calc = STS_BAD_LINK;
        end else if (is_trunc) begin
            status_calc = STS_TRUNCATED;
        end else begin
            status_calc = STS_OK;
        end
    end

    assign out_free       = !m_valid_reg || m_tready;
    assign sts.out_free   = out_free;
    assign sts.final_item = final_item;

    // walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.start_walk) begin
            cur_reg <= start_cluster;
            cnt_reg <= '0;
        end else if (cmd.emit && !final_item) begin
            cur_reg <= entry;
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_walk) begin
            bad_start_reg <= (start_cluster < FIRST_DATA_CLUSTER) ||
                             (start_cluster >= END_MARK);
        end
        if (cmd.fetch) begin
            prod_reg <= {8'd0, cur_reg - FIRST_DATA_CLUSTER} *
                        {12'd0, sectors_per_cluster};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            cluster_reg <= cur_reg;
            sector_reg  <= sector_calc;
            last_reg    <= final_item;
            status_reg  <= status_calc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign cluster  = cluster_reg;
    assign sector   = sector_reg;
    assign last     = last_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire
